// ===== rtl/core/ucad_pkg.sv =====
// ----------------------------------------------------------------------------
// ucad_pkg
// Shared constants and helpers for the unsigned-to-ASCII digit converter.
// ----------------------------------------------------------------------------
package ucad_pkg;

    // Width of the number that is converted.
    localparam int VALUE_BITS = 32;

    // Decimal digits of the widest value: floor(n * log10(2)) + 1.
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

    // Hexadecimal digits of the widest value.
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;

    // Digit slots in the conversion register.
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIGIT_REG_W = NUM_DIGITS * 4;

    // Counter widths.
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

    // Radix select codes.
    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // ASCII codes of the digit characters.
    localparam logic [6:0] ASCII_ZERO   = 7'h30;
    localparam logic [6:0] ASCII_A_BASE = 7'h37;

    // Map one digit (0 to 15) to its upper-case ASCII character.
    function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit);
        logic [6:0] base;
        base = (digit < 4'd10) ? ASCII_ZERO : ASCII_A_BASE;
        return base + {3'b000, digit};
    endfunction

endpackage : ucad_pkg

// ===== rtl/core/unsigned_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_core
// Converts an unsigned number to ASCII decimal or upper-case hexadecimal
// characters, most significant first, without leading zeros.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------
//   input   | in        | i_valid / o_stall  | i_value, i_mode
//   output  | out       | o_valid / i_stall  | o_ascii_char, o_last
//
// Each item is loaded in S_IDLE, converted bit-serially in S_CONV, one step
// per value bit, and sent in S_EMIT, one step per digit slot, which waits
// while the output is stalled. Decimal conversion is shift-and-add-3.
// Leading zero digits are dropped during the digit cycles without a beat.
// Reset is synchronous and active low; it clears the state machine and the
// output valid. A new item is accepted once the last character has been
// placed in the output register, even while that beat still waits.
//
module unsigned_to_ascii_digits_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ucad_pkg::VALUE_BITS-1:0] i_value,
    input  logic                            i_mode,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [6:0]                      o_ascii_char,
    output logic                            o_last
);
    import ucad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [VALUE_BITS-1:0]    r_bin, n_bin;
    logic [DIGIT_REG_W-1:0]   r_dig, n_dig;
    logic                     r_mode, n_mode;
    logic [BIT_CNT_W-1:0]     r_bcnt, n_bcnt;
    logic [DIGIT_CNT_W-1:0]   r_dcnt, n_dcnt;
    logic                     r_seen, n_seen;
    logic                     r_valid, n_valid;
    logic [6:0]               r_char, n_char;
    logic                     r_last, n_last;

    logic [DIGIT_REG_W-1:0]   adj_dig;
    logic [3:0]               top_dig;
    logic                     out_free;
    logic                     skip;

    // Add 3 to every decimal digit of 5 or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_mode == MODE_DEC && r_dig[i*4 +: 4] >= 4'd5) begin
                adj_dig[i*4 +: 4] = r_dig[i*4 +: 4] + 4'd3;
            end else begin
                adj_dig[i*4 +: 4] = r_dig[i*4 +: 4];
            end
        end
    end

    // Digit under the emit pointer and leading-zero skip.
    assign top_dig  = r_dig[DIGIT_REG_W-1 -: 4];
    assign out_free = !r_valid || !i_stall;
    assign skip     = (top_dig == 4'd0) && !r_seen && (r_dcnt != DIGIT_CNT_W'(1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_dig   = r_dig;
        n_mode  = r_mode;
        n_bcnt  = r_bcnt;
        n_dcnt  = r_dcnt;
        n_seen  = r_seen;
        n_valid = r_valid && i_stall;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bin   = i_value;
                    n_dig   = '0;
                    n_mode  = i_mode;
                    n_bcnt  = BIT_CNT_W'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_dig  = {adj_dig[DIGIT_REG_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_bcnt = r_bcnt - BIT_CNT_W'(1);
                if (r_bcnt == BIT_CNT_W'(1)) begin
                    n_dcnt  = DIGIT_CNT_W'(NUM_DIGITS);
                    n_seen  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_dig  = {r_dig[DIGIT_REG_W-5:0], 4'b0000};
                    n_dcnt = r_dcnt - DIGIT_CNT_W'(1);
                    if (!skip) begin
                        n_valid = 1'b1;
                        n_char  = digit_to_ascii(top_dig);
                        n_last  = (r_dcnt == DIGIT_CNT_W'(1));
                        n_seen  = 1'b1;
                    end
                    if (r_dcnt == DIGIT_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_dig  <= n_dig;
        r_mode <= n_mode;
        r_bcnt <= n_bcnt;
        r_dcnt <= n_dcnt;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

    // An accepted item always starts the bit-serial conversion.
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CONV))
        else $error("accepted beat did not start conversion");

    // Every output character is a legal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ascii_char >= 7'h30 && o_ascii_char <= 7'h39) ||
                     (o_ascii_char >= 7'h41 && o_ascii_char <= 7'h46)))
        else $error("output character is not a digit");

    // A character is loaded only once the previous beat has left.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_ascii_char) && $stable(o_last)))
        else $error("stalled output beat was overwritten");

endmodule : unsigned_to_ascii_digits_core

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unsigned_to_ascii_digits_core. A short table of
// numbers runs first: zero, the largest value in both radixes, the digit
// count boundaries and mixed bit patterns. About 450 random numbers follow,
// biased toward short numbers and powers of ten. Every character beat is
// compared with hand-written or model-predicted digits. Sender gaps and
// receiver stalls change from phase to phase. One phase holds the output off
// long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ucad_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 60;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int NUM_CASES        = 20;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;

    // One output beat: a character and its end-of-number flag.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char_beat;

    // One directed number; an empty text means the model supplies the digits.
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  mode;
        string                 text;
    } t_digit_case;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  i_mode  = MODE_DEC;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [6:0]            o_ascii_char;
    logic                  o_last;

    t_char_beat expected_chars[$];
    int errors        = 0;
    int numbers_sent  = 0;
    int hex_numbers   = 0;
    int chars_checked = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    t_digit_case digit_cases [NUM_CASES] = '{
        '{32'd0,          MODE_DEC, "0"},
        '{32'd0,          MODE_HEX, "0"},
        '{32'd1,          MODE_DEC, "1"},
        '{32'd9,          MODE_DEC, "9"},
        '{32'd10,         MODE_DEC, "10"},
        '{32'd15,         MODE_HEX, "F"},
        '{32'd16,         MODE_HEX, "10"},
        '{32'hFFFF_FFFF,  MODE_DEC, "4294967295"},
        '{32'hFFFF_FFFF,  MODE_HEX, "FFFFFFFF"},
        '{32'h8000_0000,  MODE_DEC, "2147483648"},
        '{32'h8000_0000,  MODE_HEX, "80000000"},
        '{32'd999999999,  MODE_DEC, "999999999"},
        '{32'd1000000000, MODE_DEC, "1000000000"},
        '{32'hABCD_EF01,  MODE_HEX, "ABCDEF01"},
        '{32'h0000_0100,  MODE_DEC, ""},
        '{32'h0000_FFFF,  MODE_HEX, ""},
        '{32'h5555_5555,  MODE_DEC, ""},
        '{32'hAAAA_AAAA,  MODE_HEX, ""},
        '{32'h7FFF_FFFF,  MODE_DEC, ""},
        '{32'h1234_5678,  MODE_HEX, ""}
    };

    unsigned_to_ascii_digits_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_mode       (i_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    // Free-running 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Queue the characters of a number, most significant first, by repeated
    // division by the radix.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                           input logic mode);
        longint unsigned rest;
        int unsigned     radix;
        logic [3:0]      digit;
        logic [6:0]      low_first[$];
        t_char_beat      beat;
        rest  = value;
        radix = (mode == MODE_HEX) ? 16 : 10;
        do begin
            digit = 4'(rest % radix);
            low_first.push_back((digit < 4'd10) ? ASCII_ZERO + 7'(digit)
                                                : CHAR_UPPER_A + 7'(digit - 4'd10));
            rest = rest / radix;
        end while (rest != 0);
        while (low_first.size() > 0) begin
            beat.ch   = low_first.pop_back();
            beat.last = (low_first.size() == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Queue a hand-written digit string.
    function automatic void push_text(input string text);
        t_char_beat beat;
        for (int k = 0; k < text.len(); k++) begin
            beat.ch   = 7'(text[k]);
            beat.last = (k == text.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Offer one number after a random gap and hold it until it is taken.
    task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic mode,
                               input string text);
        logic taken;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = value;
        i_mode  = mode;
        taken   = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
        end
        if (text.len() > 0) begin
            push_text(text);
        end else begin
            predict_digits(value, mode);
        end
        numbers_sent++;
        if (mode == MODE_HEX) begin
            hex_numbers++;
        end
    endtask

    // Drop valid and wait until every queued character has come out.
    task automatic drain_output();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver stalls: random per phase, or a long hold when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            i_stall     = 1'b1;
        end else begin
            i_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each character beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, char %h last %b", $time, o_ascii_char, o_last);
            end else begin
                want = expected_chars.pop_front();
                if (o_ascii_char !== want.ch) begin
                    errors++;
                    $display("%0t: ascii_char expected %h actual %h",
                             $time, want.ch, o_ascii_char);
                end
                if (o_last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                end
            end
        end
    end

    // Stop a hung run: too many cycles without a beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d characters outstanding",
                         $time, WATCHDOG_LIMIT, expected_chars.size());
                $display("FAIL unsigned_to_ascii_digits_core");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then three random phases.
    initial begin
        int                    send_pcts [3];
        int                    stall_pcts[3];
        logic [VALUE_BITS-1:0] number;
        logic [VALUE_BITS-1:0] power;
        send_pcts  = '{32, 83, 0};
        stall_pcts = '{83, 32, 0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = send_pcts[0];
        recv_stall_pct = stall_pcts[0];
        foreach (digit_cases[n]) begin
            send_number(digit_cases[n].value, digit_cases[n].mode, digit_cases[n].text);
        end
        drain_output();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // With no idling, hold the output off while numbers keep coming.
                if (phase == 2 && n == 40) begin
                    hold_asked++;
                end
                case ($urandom_range(0, 3))
                    0: number = $urandom;
                    1: number = $urandom >> $urandom_range(0, 31);
                    2: number = $urandom_range(0, 20);
                    default: begin
                        // Near a power of ten, where the digit count steps.
                        power = 1;
                        repeat ($urandom_range(0, 9)) power = power * 10;
                        number = power - $urandom_range(0, 1);
                    end
                endcase
                send_number(number, 1'($urandom_range(0, 1)), "");
            end
            drain_output();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            errors++;
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_chars.size());
        end

        $display("Converted %0d numbers (%0d hex, %0d decimal) into %0d checked characters,",
                 numbers_sent, hex_numbers, numbers_sent - hex_numbers, chars_checked);
        $display("under three gap/stall mixes and one %0d-cycle output hold.", HOLD_CYCLES);
        if (errors == 0) begin
            $display("PASS unsigned_to_ascii_digits_core");
        end else begin
            $display("FAIL unsigned_to_ascii_digits_core");
        end
        $finish;
    end

endmodule : tb_top

// ===== filelist.f =====
rtl/core/ucad_pkg.sv
rtl/core/unsigned_to_ascii_digits_core.sv
test/tb_top.sv
